[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the timer bank rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank assertion failed");

// next-cycle implication
`define TT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank assertion failed");

`endif

[rtl/tt_pkg.sv]
// ---------------------------------------------------------------------------
// tt_pkg
// types, codes and defaults shared by the timer bank modules
// ---------------------------------------------------------------------------
package tt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int COUNT_BITS_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int TICKS_W  = 32;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK    = 3'd0,
        FN_CREATE  = 3'd1,
        FN_START   = 3'd2,
        FN_STOP    = 3'd3,
        FN_SETCNT  = 3'd4,
        FN_RELEASE = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_UNALLOC = 2'd1,
        STS_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_LAST
    } t_state;

    typedef struct packed {
        logic exec;
        logic tick_start;
        logic sweep;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic last;
    } t_sts;

endpackage

[rtl/tt_ram.sv]
// ---------------------------------------------------------------------------
// tt_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module tt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tt_ctrl.sv]
// ---------------------------------------------------------------------------
// tt_ctrl
// request sequencing: create, start, stop, set count, release and the tick sweep
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tt_ctrl
    import tt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_func i_func,
    input  logic  i_stall,
    input  t_sts  i_sts,
    output logic  o_stall,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE) | (i_sts.out_busy & i_stall);
        in_acc  = i_valid & ~o_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_func == FN_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = ST_SWEEP;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `TT_ASSERT_NEXT(a_tick_enters_sweep, i_clk, i_rst_n, o_cmd.tick_start, r_state == ST_SWEEP)
    `TT_ASSERT_NEXT(a_last_then_idle, i_clk, i_rst_n, o_cmd.finish, r_state == ST_IDLE)

endmodule

[rtl/tt_dp.sv]
// ---------------------------------------------------------------------------
// tt_dp
// slot flags, count and reload storage, sweep pipeline and result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tt_dp
    import tt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  t_func               i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [TICKS_W-1:0]  i_ticks,
    input  logic                i_run,
    input  logic                i_stall,
    output t_sts                o_sts,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [MASK_W-1:0]   o_expired_mask
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]      r_alloc;
    logic [SLOTS-1:0]      n_alloc;
    logic [SLOTS-1:0]      r_run;
    logic [SLOTS-1:0]      n_run;
    logic [SLOTS-1:0]      r_mask;
    logic [SLOTS-1:0]      n_mask;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_wb_vld;
    logic [IDX_W-1:0]      r_wb_idx;
    logic [SLOT_W-1:0]     r_tick_slot;
    logic                  r_ovld;
    t_status               r_status;
    logic [SLOT_W-1:0]     r_slot_out;
    logic [SLOTS-1:0]      r_omask;

    logic [COUNT_BITS-1:0] ticks_c;
    logic [IDX_W-1:0]      slot_idx;
    logic                  slot_ok;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    t_status               op_status;
    logic [SLOT_W-1:0]     op_slot_out;

    logic [COUNT_BITS-1:0] cnt_rd;
    logic [COUNT_BITS-1:0] rel_rd;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic                  wb_exp;
    logic [COUNT_BITS-1:0] wb_cnt;

    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  rel_we;

    assign ticks_c  = i_ticks[COUNT_BITS-1:0];
    assign slot_idx = i_slot[IDX_W-1:0];
    assign slot_ok  = ({1'b0, i_slot} < (SLOT_W + 1)'(SLOTS)) && r_alloc[slot_idx];

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // create, start, stop, set count and release operations
    always_comb begin
        n_alloc     = r_alloc;
        n_run       = r_run;
        op_status   = STS_OK;
        op_slot_out = i_slot;
        cnt_we      = 1'b0;
        rel_we      = 1'b0;
        unique case (i_func)
            FN_CREATE: begin
                if (free_found) begin
                    n_alloc[free_idx] = 1'b1;
                    n_run[free_idx]   = i_run;
                    op_slot_out       = SLOT_W'(free_idx);
                    cnt_we            = i_cmd.exec;
                    rel_we            = i_cmd.exec;
                end else begin
                    op_status = STS_FULL;
                end
            end
            FN_START, FN_STOP, FN_SETCNT, FN_RELEASE: begin
                if (!slot_ok) begin
                    op_status = STS_UNALLOC;
                end else if (i_func == FN_START) begin
                    n_run[slot_idx] = 1'b1;
                end else if (i_func == FN_STOP) begin
                    n_run[slot_idx] = 1'b0;
                end else if (i_func == FN_SETCNT) begin
                    cnt_we = i_cmd.exec;
                end else begin
                    n_alloc[slot_idx] = 1'b0;
                    n_run[slot_idx]   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // sweep writeback stage
    assign cnt_dec = (cnt_rd != '0) ? (cnt_rd - 1'b1) : cnt_rd;
    assign wb_exp  = r_alloc[r_wb_idx] & r_run[r_wb_idx] & (cnt_dec == '0);
    assign wb_cnt  = wb_exp ? rel_rd : cnt_dec;

    always_comb begin
        n_mask = r_mask;
        if (r_wb_vld) begin
            n_mask[r_wb_idx] = wb_exp;
        end
    end

    assign cnt_waddr = r_wb_vld ? r_wb_idx : ((i_func == FN_CREATE) ? free_idx : slot_idx);
    assign cnt_wdata = r_wb_vld ? wb_cnt : ticks_c;

    tt_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOTS),
        .ADDR_W(IDX_W)
    ) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (r_wb_vld | cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(cnt_wdata),
        .i_raddr(r_idx),
        .o_rdata(cnt_rd)
    );

    tt_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOTS),
        .ADDR_W(IDX_W)
    ) u_rel_ram (
        .i_clk  (i_clk),
        .i_we   (rel_we),
        .i_waddr(free_idx),
        .i_wdata(ticks_c),
        .i_raddr(r_idx),
        .o_rdata(rel_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc  <= '0;
            r_run    <= '0;
            r_wb_vld <= 1'b0;
            r_idx    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_alloc <= n_alloc;
                r_run   <= n_run;
            end
            r_wb_vld <= i_cmd.sweep;
            if (i_cmd.tick_start) begin
                r_idx <= '0;
            end else if (i_cmd.sweep && !o_sts.last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.exec || i_cmd.finish) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_idx;
        if (i_cmd.tick_start) begin
            r_mask      <= '0;
            r_tick_slot <= i_slot;
        end else begin
            r_mask <= n_mask;
        end
        if (i_cmd.exec) begin
            r_status   <= op_status;
            r_slot_out <= op_slot_out;
            r_omask    <= '0;
        end else if (i_cmd.finish) begin
            r_status   <= STS_OK;
            r_slot_out <= r_tick_slot;
            r_omask    <= n_mask;
        end
    end

    assign o_sts.out_busy = r_ovld;
    assign o_sts.last     = (r_idx == IDX_W'(SLOTS - 1));
    assign o_valid        = r_ovld;
    assign o_status       = r_status;
    assign o_slot_out     = r_slot_out;
    assign o_expired_mask = MASK_W'(r_omask);

    `TT_ASSERT_NOW(a_finish_has_writeback, i_clk, i_rst_n, i_cmd.finish, r_wb_vld)
    `TT_ASSERT_NOW(a_result_from_cmd, i_clk, i_rst_n, $rose(r_ovld), $past(i_cmd.exec || i_cmd.finish))

endmodule

[rtl/tick_timer_bank.sv]
// ---------------------------------------------------------------------------
// tick_timer_bank
// bank of auto-reload software timer slots driven by tick requests
// ---------------------------------------------------------------------------
// Create, start, stop, set count and release finish at the edge that accepts
// the request, where their result is registered. A tick sweeps the slots one
// per cycle through the count and reload memories (one read port each,
// registered read); its result is registered together with the writeback of
// the last slot, and the next request can be accepted in the same cycle that
// result is shown. A result held in the output register by a stalled
// receiver blocks the next request until it is taken.
module tick_timer_bank
    import tt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [TICKS_W-1:0]  i_ticks,
    input  logic                i_run,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [MASK_W-1:0]   o_expired_mask
);

    t_cmd  cmd;
    t_sts  sts;
    t_func func;

    assign func = t_func'(i_func);

    tt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_func (func),
        .i_stall(i_stall),
        .i_sts  (sts),
        .o_stall(o_stall),
        .o_cmd  (cmd)
    );

    tt_dp #(
        .SLOTS     (SLOTS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (func),
        .i_slot        (i_slot),
        .i_ticks       (i_ticks),
        .i_run         (i_run),
        .i_stall       (i_stall),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_expired_mask(o_expired_mask)
    );

endmodule

[verif/tick_timer_bank_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tick_timer_bank_test
// self-checking bench for the tick timer bank
// ---------------------------------------------------------------------------
// Requests go in through the valid/stall input channel with random gaps.
// A shadow copy of the timer slots predicts each response as its request is
// accepted. Separate processes stall the response channel at random and
// compare every accepted response with the oldest prediction. Directed
// checks cover errors on free slots, filling the bank, expiry with zero and
// stopped counts and the spare opcodes. Random traffic follows, with one
// long response hold-off that backs the bank up into its input.
// ---------------------------------------------------------------------------
module tick_timer_bank_test
    import tt_pkg::*;
();

    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [MASK_W-1:0]   mask;
    } t_timer_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func = '0;
    logic [SLOT_W-1:0]   i_slot = '0;
    logic [TICKS_W-1:0]  i_ticks = '0;
    logic                i_run = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_out;
    logic [MASK_W-1:0]   o_expired_mask;

    // shadow timer slots
    logic [TICKS_W-1:0] tmr_count [SLOTS_DEF];
    logic [TICKS_W-1:0] tmr_reload [SLOTS_DEF];
    bit                 tmr_running [SLOTS_DEF];
    bit                 tmr_used [SLOTS_DEF];

    t_timer_result pending_results[$];

    bit no_idle = 1'b0;
    bit hold_request = 1'b0;
    int n_fail = 0;
    int n_requests = 0;
    int n_ticks = 0;
    int n_expired = 0;
    int n_full = 0;
    int n_unalloc = 0;
    int idle_cycles = 0;

    tick_timer_bank i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_ticks        (i_ticks),
        .i_run          (i_run),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot_out     (o_slot_out),
        .o_expired_mask (o_expired_mask)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
            tmr_count[i]   = '0;
            tmr_reload[i]  = '0;
            tmr_running[i] = 1'b0;
            tmr_used[i]    = 1'b0;
        end
    end

    function automatic t_timer_result predict_result(input logic [FUNC_W-1:0] func,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [TICKS_W-1:0] ticks,
                                                     input logic run);
        t_timer_result res;
        bit found;
        res.status   = STS_OK;
        res.slot_out = slot;
        res.mask     = '0;
        found        = 1'b0;
        case (func)
            FN_TICK: begin
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    if (tmr_used[i]) begin
                        if (tmr_count[i] != '0) tmr_count[i] = tmr_count[i] - 1'b1;
                        if (tmr_count[i] == '0 && tmr_running[i]) begin
                            res.mask[i]  = 1'b1;
                            tmr_count[i] = tmr_reload[i];
                        end
                    end
                end
            end
            FN_CREATE: begin
                res.status = STS_FULL;
                for (int i = 0; i < SLOTS_DEF && !found; i++) begin
                    if (!tmr_used[i]) begin
                        found          = 1'b1;
                        tmr_used[i]    = 1'b1;
                        tmr_count[i]   = ticks;
                        tmr_reload[i]  = ticks;
                        tmr_running[i] = run;
                        res.status     = STS_OK;
                        res.slot_out   = i[SLOT_W-1:0];
                    end
                end
            end
            FN_START, FN_STOP, FN_SETCNT, FN_RELEASE: begin
                if (!tmr_used[slot]) begin
                    res.status = STS_UNALLOC;
                end else if (func == FN_START) begin
                    tmr_running[slot] = 1'b1;
                end else if (func == FN_STOP) begin
                    tmr_running[slot] = 1'b0;
                end else if (func == FN_SETCNT) begin
                    tmr_count[slot] = ticks;
                end else begin
                    tmr_used[slot]    = 1'b0;
                    tmr_running[slot] = 1'b0;
                    tmr_count[slot]   = '0;
                    tmr_reload[slot]  = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                                input logic [TICKS_W-1:0] ticks, input logic run);
        int gap;
        t_timer_result res;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func  <= func;
        i_slot  <= slot;
        i_ticks <= ticks;
        i_run   <= run;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        res = predict_result(func, slot, ticks, run);
        pending_results.push_back(res);
        n_requests++;
        if (func == FN_TICK) n_ticks++;
        n_expired += $countones(res.mask);
        if (res.status == STS_FULL) n_full++;
        if (res.status == STS_UNALLOC) n_unalloc++;
    endtask

    // response side: random stall per response, one long hold-off on demand
    initial begin : response_sink
        int wait_cycles;
        forever begin
            if (hold_request) wait_cycles = HOLD_CYCLES;
            else wait_cycles = no_idle ? 0 : $urandom_range(0, 6);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                hold_request = 1'b0;
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_rst_n));
        end
    end

    always @(posedge i_clk) begin
        t_timer_result exp_res;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("unexpected response: status %0d slot %0d mask %h",
                             o_status, o_slot_out, o_expired_mask);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status || o_slot_out !== exp_res.slot_out ||
                    o_expired_mask !== exp_res.mask) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("mismatch: status %0d/%0d slot %0d/%0d mask %h/%h (exp/act)",
                                 exp_res.status, o_status, exp_res.slot_out, o_slot_out,
                                 exp_res.mask, o_expired_mask);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic test_free_slot_errors();
        send_request(FN_START, 4'd15, 32'd0, 1'b0);
        send_request(FN_STOP, 4'd0, 32'd0, 1'b1);
        send_request(FN_SETCNT, 4'd7, 32'hFFFF_FFFF, 1'b0);
        send_request(FN_RELEASE, 4'd15, 32'd0, 1'b0);
    endtask

    task automatic test_fill_bank();
        send_request(FN_CREATE, 4'd9, 32'd0, 1'b1);
        send_request(FN_CREATE, 4'd0, 32'd1, 1'b0);
        send_request(FN_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b1);
        for (int i = 3; i < SLOTS_DEF; i++)
            send_request(FN_CREATE, 4'd0, 32'd2, i[0]);
        send_request(FN_CREATE, 4'd11, 32'd5, 1'b1);
    endtask

    task automatic test_tick_expiry();
        send_request(FN_TICK, 4'd0, 32'd0, 1'b0);
        send_request(FN_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_spare_codes();
        send_request(FN_SPARE_A, 4'd3, 32'd7, 1'b1);
        send_request(FN_SPARE_B, 4'd12, 32'h8000_0000, 1'b0);
    endtask

    task automatic test_slot_updates();
        send_request(FN_RELEASE, 4'd3, 32'd0, 1'b0);
        send_request(FN_SETCNT, 4'd1, 32'd5, 1'b0);
    endtask

    task automatic test_random_mix(input int n_items);
        int sel;
        logic [FUNC_W-1:0]  func;
        logic [SLOT_W-1:0]  slot;
        logic [TICKS_W-1:0] ticks;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) func = FN_TICK;
            else if (sel < 52) func = FN_CREATE;
            else if (sel < 62) func = FN_START;
            else if (sel < 72) func = FN_STOP;
            else if (sel < 82) func = FN_SETCNT;
            else if (sel < 96) func = FN_RELEASE;
            else func = sel[0] ? FN_SPARE_A : FN_SPARE_B;
            // lean toward slots that are in use
            slot = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
            repeat (6) if (!tmr_used[slot]) slot = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
            sel = $urandom_range(0, 99);
            if (sel < 60) ticks = $urandom_range(0, 6);
            else if (sel < 80) ticks = $urandom_range(0, 40);
            else if (sel < 92) ticks = $urandom;
            else ticks = 32'hFFFF_FFFF - $urandom_range(0, 3);
            send_request(func, slot, ticks, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_backpressure();
        no_idle      = 1'b1;
        hold_request = 1'b1;
        test_random_mix(60);
        no_idle      = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_free_slot_errors();
        test_fill_bank();
        test_tick_expiry();
        test_spare_codes();
        test_slot_updates();
        test_random_mix(900);
        no_idle = 1'b1;
        test_random_mix(300);
        no_idle = 1'b0;
        test_backpressure();
        test_random_mix(740);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS_DEF + 4) @(posedge i_clk);
        n_fail += pending_results.size();
        $display("%0d requests, %0d ticks, %0d timer expirations", n_requests, n_ticks,
                 n_expired);
        $display("%0d creates on a full bank, %0d requests to free slots, %0d failures",
                 n_full, n_unalloc, n_fail);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[tick_timer_bank.f]
+incdir+rtl
rtl/tt_pkg.sv
rtl/tt_ram.sv
rtl/tt_ctrl.sv
rtl/tt_dp.sv
rtl/tick_timer_bank.sv
verif/tick_timer_bank_test.sv
